### hw/rtl/gfa_pkg.sv
// gfa_pkg: shared constants, types and tables of the griewank fitness unit
// no dependencies; used by every module of the block
package gfa_pkg;

	localparam int GFA_MAX_DIM  = 1024;
	localparam int GFA_DIV_W    = 17;
	localparam int GFA_DIV_N    = 64;
	localparam int GFA_CORDIC_N = 30;

	localparam logic [40:0] GFA_TWO_PI  = 41'd6746518852;
	localparam logic [40:0] GFA_PI      = 41'd3373259426;
	localparam logic [40:0] GFA_HALF_PI = 41'd1686629713;
	localparam logic signed [33:0] GFA_GAIN    = 34'sd652032874;
	localparam logic signed [33:0] GFA_Q30_ONE = 34'sd1073741824;
	localparam logic [36:0] GFA_FIT_MAX = 37'h1F_FFFF_FFFF;
	localparam logic [63:0]          GFA_SUM_HALF = 64'd2000;
	localparam logic [63:0]          GFA_RSQ_NUM  = 64'h1000_0000_0000_0000;
	// ceil(2^30/125), exact quotient for dividends below 2^23
	localparam logic [23:0]          GFA_REC125   = 24'd8589935;

	typedef struct packed {
		logic                 start;
		logic [63:0]          dividend;
		logic [GFA_DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

	function automatic logic signed [33:0] gfa_atan(input logic [4:0] i);
		logic signed [33:0] a;
		case (i)
			5'd0:  a = 34'sd843314857;
			5'd1:  a = 34'sd497837829;
			5'd2:  a = 34'sd263043836;
			5'd3:  a = 34'sd133525158;
			5'd4:  a = 34'sd67021686;
			5'd5:  a = 34'sd33543515;
			5'd6:  a = 34'sd16775850;
			5'd7:  a = 34'sd8388437;
			5'd8:  a = 34'sd4194282;
			5'd9:  a = 34'sd2097149;
			5'd10: a = 34'sd1048575;
			5'd11: a = 34'sd524287;
			5'd12: a = 34'sd262143;
			5'd13: a = 34'sd131071;
			5'd14: a = 34'sd65535;
			5'd15: a = 34'sd32767;
			5'd16: a = 34'sd16383;
			5'd17: a = 34'sd8191;
			5'd18: a = 34'sd4095;
			5'd19: a = 34'sd2047;
			5'd20: a = 34'sd1023;
			5'd21: a = 34'sd511;
			5'd22: a = 34'sd255;
			5'd23: a = 34'sd127;
			5'd24: a = 34'sd63;
			5'd25: a = 34'sd31;
			5'd26: a = 34'sd15;
			5'd27: a = 34'sd7;
			5'd28: a = 34'sd3;
			5'd29: a = 34'sd1;
			default: a = 34'sd0;
		endcase
		return a;
	endfunction

endpackage

### hw/rtl/gfa_vec_if.sv
// gfa_vec_if: coordinate item channel, valid/ready with coord and last
// no dependencies
interface gfa_vec_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] coord;
	logic               last;
	modport source(output valid, coord, last, input ready);
	modport sink(input valid, coord, last, output ready);
endinterface

### hw/rtl/gfa_res_if.sv
// gfa_res_if: result item channel, valid/ready with fitness and overflow flag
// no dependencies
interface gfa_res_if;
	logic        valid;
	logic        ready;
	logic [36:0] fitness;
	logic        dim_overflow;
	modport source(output valid, fitness, dim_overflow, input ready);
	modport sink(input valid, fitness, dim_overflow, output ready);
endinterface

### hw/rtl/gfa_div.sv
// gfa_div: serial restoring divider, one quotient bit per cycle
// depends on gfa_pkg
module gfa_div import gfa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int CNT_W = $clog2(GFA_DIV_N);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [63:0]          num_q;
	logic [GFA_DIV_W-1:0] rem_q;
	logic [GFA_DIV_W-1:0] den_q;
	logic [GFA_DIV_W:0]   trial;
	logic [GFA_DIV_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, num_q[63]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(GFA_DIV_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], ge};
			rem_q <= ge ? diff[GFA_DIV_W-1:0] : trial[GFA_DIV_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q)) else $error("divider done without work");
`endif
endmodule

### hw/rtl/gfa_cordic.sv
// gfa_cordic: rotation-mode cordic cosine, one iteration per cycle
// depends on gfa_pkg for the arctangent table and gain
module gfa_cordic import gfa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [30:0]        angle,
	input  logic               neg,
	output logic               done,
	output logic signed [31:0] cosv
);
	logic               busy_q;
	logic               done_q;
	logic [4:0]         i_q;
	logic               neg_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [33:0] z_q;
	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [33:0] at;
	logic signed [33:0] cl;

	assign dx = cy_q >>> i_q;
	assign dy = cx_q >>> i_q;
	assign at = gfa_atan(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(GFA_CORDIC_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q  <= GFA_GAIN;
			cy_q  <= '0;
			z_q   <= $signed({3'b0, angle});
			neg_q <= neg;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				z_q  <= z_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				z_q  <= z_q + at;
			end
		end
	end

	always_comb begin
		if (cx_q[33])
			cl = '0;
		else if (cx_q > GFA_Q30_ONE)
			cl = GFA_Q30_ONE;
		else
			cl = cx_q;
	end

	assign cosv = neg_q ? -cl[31:0] : cl[31:0];
	assign done = done_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("cordic restarted while busy");
`endif
endmodule

### hw/rtl/griewank_fitness_accumulator_unit.sv
// griewank_fitness_accumulator_unit: top level, sequencer, shared multiplier
// depends on gfa_pkg, gfa_vec_if, gfa_res_if, gfa_div, gfa_cordic
//
// Coordinates of one vector arrive one item at a time; the item flagged last
// yields one result item, sum(x^2)/4000 - prod(cos(x/sqrt(i+1))) + 1 in Q.20.
// Each coordinate is accepted, then squared, then runs the serial division
// 2^60/(i+1) and the square root that give 1/sqrt(i+1), the angle product
// and modulo-2*pi reduction, the quadrant fold and the cordic, and the
// product update. The last coordinate then adds the division by 4000, four
// 16-bit digits by reciprocal multiplication on the shared multiplier, and
// the load of the result register, which stalls while an earlier result is
// not yet taken. Coordinates past MAX_DIM skip the computation and set the
// overflow flag. ready is high only while the sequencer is idle; a result
// waits in an output register until it is taken.
module griewank_fitness_accumulator_unit import gfa_pkg::*; #(
	parameter int MAX_DIM = GFA_MAX_DIM
) (
	input  logic clk,
	input  logic arst_n,
	gfa_vec_if.sink   vec,
	gfa_res_if.source res
);
	localparam int IDX_W = $clog2(MAX_DIM + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SQM, S_SQA, S_RDIV, S_SQRT, S_ANGM, S_MOD, S_FOLD,
		S_CORD, S_PRODM, S_PRODA, S_SDM, S_SDA, S_FIN
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   elem_q;
	logic [63:0]        sum_q;
	logic signed [31:0] prod_q;
	logic               ovf_q;
	logic               last_q;
	logic [30:0]        mag_q;
	logic [62:0]        v_q;
	logic [62:0]        r_q;
	logic [62:0]        b_q;
	logic [40:0]        ang_q;
	logic [3:0]         k_q;
	logic signed [31:0] cos_q;
	logic [63:0]        s_q;
	logic [63:0]        sd_q;
	logic [6:0]         sr_q;
	logic [1:0]         dk_q;
	logic               res_valid_q;
	logic [36:0]        fit_q;
	logic               res_ovf_q;
	logic               cord_start_q;
	logic [30:0]        cord_ang_q;
	logic               cord_neg_q;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic               cord_done;
	logic signed [31:0] cosv;

	logic [31:0]        mag_w;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_q;
	logic signed [65:0] rnd20;
	logic signed [65:0] rnd30;
	logic [62:0]        sq_t;
	logic [40:0]        tp;
	logic [40:0]        a1;
	logic [40:0]        a2;
	logic               fneg;
	logic signed [32:0] pr;
	logic signed [65:0] f;
	logic [36:0]        fcl;
	logic [22:0]        sd_t;
	logic [15:0]        sd_qd;
	logic [22:0]        sd_m;
	logic [22:0]        sd_r;

	assign div_req.start    = state_q == S_SQA;
	assign div_req.dividend = GFA_RSQ_NUM;
	assign div_req.divisor  = GFA_DIV_W'(elem_q) + GFA_DIV_W'(1);

	gfa_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	gfa_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start_q), .angle(cord_ang_q),
		.neg(cord_neg_q), .done(cord_done), .cosv(cosv)
	);

	assign mag_w = vec.coord[30] ? (32'h8000_0000 - {1'b0, vec.coord})
	                             : {1'b0, vec.coord};

	// one digit of the division by 125, remainder carried into the next digit
	assign sd_t  = {sr_q, sd_q[63:48]};
	assign sd_qd = mul_q[45:30];
	assign sd_m  = {7'b0, sd_qd} * 23'd125;
	assign sd_r  = sd_t - sd_m;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQM: begin
				mul_a = $signed({2'b0, mag_q});
				mul_b = $signed({2'b0, mag_q});
			end
			S_ANGM: begin
				mul_a = $signed({2'b0, mag_q});
				mul_b = $signed({2'b0, r_q[30:0]});
			end
			S_PRODM: begin
				mul_a = 33'(prod_q);
				mul_b = 33'(cos_q);
			end
			S_SDM: begin
				mul_a = $signed({10'b0, sd_t});
				mul_b = $signed({9'b0, GFA_REC125});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	assign rnd20 = mul_q + 66'sd524288;
	assign rnd30 = mul_q + 66'sd536870912;
	assign sq_t  = r_q + b_q;
	assign tp    = GFA_TWO_PI << k_q;
	assign a1    = (ang_q > GFA_PI) ? (GFA_TWO_PI - ang_q) : ang_q;
	assign fneg  = a1 > GFA_HALF_PI;
	assign a2    = fneg ? (GFA_PI - a1) : a1;

	assign pr = 33'(prod_q) + 33'sd512;
	assign f  = $signed({2'b0, s_q}) - 66'($signed(pr[32:10])) + 66'sd1048576;
	always_comb begin
		if (f[65])
			fcl = '0;
		else if (f > $signed({29'b0, GFA_FIT_MAX}))
			fcl = GFA_FIT_MAX;
		else
			fcl = f[36:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			elem_q       <= '0;
			sum_q        <= '0;
			prod_q       <= 32'sh4000_0000;
			ovf_q        <= 1'b0;
			res_valid_q  <= 1'b0;
			fit_q        <= '0;
			res_ovf_q    <= 1'b0;
			cord_start_q <= 1'b0;
		end else begin
			cord_start_q <= state_q == S_FOLD;
			res_valid_q  <= (state_q == S_FIN) || (res_valid_q && !res.ready);
			unique case (state_q)
				S_IDLE: begin
					if (vec.valid) begin
						if (elem_q >= IDX_W'(MAX_DIM)) begin
							ovf_q <= 1'b1;
							if (vec.last)
								state_q <= S_SDM;
						end else begin
							state_q <= S_SQM;
						end
					end
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					sum_q   <= sum_q + 64'(rnd20[60:20]);
					state_q <= S_RDIV;
				end
				S_RDIV: if (div_rsp.done) state_q <= S_SQRT;
				S_SQRT: if (b_q[0]) state_q <= S_ANGM;
				S_ANGM: state_q <= S_MOD;
				S_MOD: if (k_q == 4'd0) state_q <= S_FOLD;
				S_FOLD: state_q <= S_CORD;
				S_CORD: if (cord_done) state_q <= S_PRODM;
				S_PRODM: state_q <= S_PRODA;
				S_PRODA: begin
					prod_q  <= rnd30[61:30];
					elem_q  <= elem_q + IDX_W'(1);
					state_q <= last_q ? S_SDM : S_IDLE;
				end
				S_SDM: state_q <= S_SDA;
				S_SDA: state_q <= (dk_q == 2'd0) ? S_FIN : S_SDM;
				S_FIN: begin
					if (!res_valid_q || res.ready) begin
						fit_q     <= fcl;
						res_ovf_q <= ovf_q;
						elem_q    <= '0;
						sum_q     <= '0;
						prod_q    <= 32'sh4000_0000;
						ovf_q     <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mag_q  <= mag_w[30:0];
				last_q <= vec.last;
				sd_q   <= (sum_q + GFA_SUM_HALF) >> 5;
				sr_q   <= '0;
				dk_q   <= 2'd3;
			end
			S_RDIV: begin
				v_q <= div_rsp.quotient[62:0];
				r_q <= '0;
				b_q <= {1'b1, 62'b0};
			end
			S_SQRT: begin
				if (v_q >= sq_t) begin
					v_q <= v_q - sq_t;
					r_q <= (r_q >> 1) + b_q;
				end else begin
					r_q <= r_q >> 1;
				end
				b_q <= b_q >> 2;
			end
			S_ANGM: k_q <= 4'd8;
			S_MOD: begin
				if (k_q == 4'd8)
					ang_q <= rnd20[60:20];
				else if (ang_q >= tp)
					ang_q <= ang_q - tp;
				k_q <= k_q - 4'd1;
			end
			S_FOLD: begin
				cord_ang_q <= a2[30:0];
				cord_neg_q <= fneg;
			end
			S_CORD: if (cord_done) cos_q <= cosv;
			S_PRODA: begin
				sd_q <= (sum_q + GFA_SUM_HALF) >> 5;
				sr_q <= '0;
				dk_q <= 2'd3;
			end
			S_SDA: begin
				s_q  <= {s_q[47:0], sd_qd};
				sd_q <= sd_q << 16;
				sr_q <= sd_r[6:0];
				dk_q <= dk_q - 2'd1;
			end
			default: ;
		endcase
	end

	assign vec.ready        = state_q == S_IDLE;
	assign res.valid        = res_valid_q;
	assign res.fitness      = fit_q;
	assign res.dim_overflow = res_ovf_q;

`ifndef SYNTHESIS
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		elem_q <= IDX_W'(MAX_DIM)) else $error("element index beyond bound");
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside final state");
	a_rsqrt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ANGM |-> r_q <= 63'h4000_0000)
		else $error("reciprocal root out of range");
`endif
endmodule
